@@ rtl/lc_pkg.sv @@
`timescale 1ns / 1ps

package lc_pkg;

  localparam int COORD_W      = 16;
  localparam int IDX_W        = 16;
  localparam int RADIUS_W     = 16;
  localparam int SQ_W         = 32;
  localparam int COUNT_OUT_W  = 9;
  localparam int MAX_DIMS     = 8;
  localparam int DIMS_DEF     = 4;
  localparam int MAX_CENTERS_DEF = 256;

  // Stages from read issue to the registered match flag: RAM read, difference,
  // square, two adder tree levels, final add and compare.
  localparam int PIPE_DEPTH   = 6;
  localparam int ID_DELAY     = PIPE_DEPTH - 1;

  localparam logic [IDX_W-1:0] IDX_SAT = '1;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [IDX_W-1:0]          idx_t;
  typedef logic [RADIUS_W-1:0]       radius_t;
  typedef logic [SQ_W-1:0]           sq_t;
  typedef logic [COUNT_OUT_W-1:0]    count_out_t;

endpackage

@@ rtl/lc_in_if.sv @@
`timescale 1ns / 1ps

interface lc_in_if;
  import lc_pkg::*;

  logic   valid;
  logic   ready;
  logic   start_set;
  coord_t coord_0;
  coord_t coord_1;
  coord_t coord_2;
  coord_t coord_3;
  coord_t coord_4;
  coord_t coord_5;
  coord_t coord_6;
  coord_t coord_7;

  modport source (
    output valid, start_set, coord_0, coord_1, coord_2, coord_3,
           coord_4, coord_5, coord_6, coord_7,
    input  ready
  );

  modport sink (
    input  valid, start_set, coord_0, coord_1, coord_2, coord_3,
           coord_4, coord_5, coord_6, coord_7,
    output ready
  );

endinterface

@@ rtl/lc_out_if.sv @@
`timescale 1ns / 1ps

interface lc_out_if;
  import lc_pkg::*;

  logic       valid;
  logic       ready;
  idx_t       point_index;
  idx_t       cluster_id;
  logic       is_new_center;
  logic       table_overflow;
  count_out_t center_count;

  modport source (
    output valid, point_index, cluster_id, is_new_center, table_overflow,
           center_count,
    input  ready
  );

  modport sink (
    input  valid, point_index, cluster_id, is_new_center, table_overflow,
           center_count,
    output ready
  );

endinterface

@@ rtl/lc_ram.sv @@
`timescale 1ns / 1ps

module lc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/lc_lane.sv @@
`timescale 1ns / 1ps

module lc_lane #(
  parameter int MAX_CENTERS = 256
) (
  input  logic                           clk,
  input  logic                           wr_en,
  input  logic [$clog2(MAX_CENTERS)-1:0] wr_addr,
  input  lc_pkg::coord_t                 wr_data,
  input  logic                           rd_en,
  input  logic [$clog2(MAX_CENTERS)-1:0] rd_addr,
  input  lc_pkg::coord_t                 coord,
  output lc_pkg::sq_t                    sq
);
  import lc_pkg::*;

  logic [COORD_W-1:0]      center_q;
  logic signed [COORD_W:0] diff;
  logic signed [2*COORD_W+1:0] prod;

  lc_ram #(
    .WIDTH (COORD_W),
    .DEPTH (MAX_CENTERS)
  ) u_coord_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (center_q)
  );

  assign prod = diff * diff;

  always_ff @(posedge clk) begin
    diff <= {coord[COORD_W-1], coord} - {center_q[COORD_W-1], center_q};
    sq   <= prod[SQ_W-1:0];
  end

endmodule

@@ rtl/lc_merge.sv @@
`timescale 1ns / 1ps

module lc_merge #(
  parameter int DIMS = 4
) (
  input  logic        clk,
  input  lc_pkg::sq_t sq [DIMS],
  input  lc_pkg::sq_t r2,
  output logic        hit
);
  import lc_pkg::*;

  sq_t             leaf [MAX_DIMS];
  logic [SQ_W:0]   lvl1 [MAX_DIMS/2];
  logic [SQ_W+1:0] lvl2 [MAX_DIMS/4];
  logic [SQ_W+2:0] total;

  for (genvar i = 0; i < MAX_DIMS; i++) begin : g_leaf
    if (i < DIMS) begin : g_used
      assign leaf[i] = sq[i];
    end else begin : g_pad
      assign leaf[i] = '0;
    end
  end

  assign total = {1'b0, lvl2[0]} + {1'b0, lvl2[1]};

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_DIMS/2; i++) begin
      lvl1[i] <= {1'b0, leaf[2*i]} + {1'b0, leaf[2*i+1]};
    end
    for (int i = 0; i < MAX_DIMS/4; i++) begin
      lvl2[i] <= {1'b0, lvl1[2*i]} + {1'b0, lvl1[2*i+1]};
    end
    hit <= (total <= {3'b000, r2});
  end

endmodule

@@ rtl/leader_clustering.sv @@
`timescale 1ns / 1ps

// Leader clustering: each word on in_ch is one point, compared with the stored
// centres in the order they were stored, one centre per cycle, with DIMS
// coordinate lanes working side by side and an adder tree merging their squared
// differences. Centres are read through the single read port of the centre
// memories into the six-stage compare pipeline, which drains at the end of the
// scan, and a result is held back while the previous result still waits on
// out_ch. A new point is accepted while the previous result still waits on
// out_ch. The radius is to be written through cfg_we and cfg_wdata only while
// the block is idle; the block itself does not enforce this. start_set on a
// point empties the table and restarts the point count.

module leader_clustering #(
  parameter int DIMS        = lc_pkg::DIMS_DEF,
  parameter int MAX_CENTERS = lc_pkg::MAX_CENTERS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  lc_pkg::radius_t cfg_wdata,
  lc_in_if.sink           in_ch,
  lc_out_if.source        out_ch
);
  import lc_pkg::*;

  localparam int AW = $clog2(MAX_CENTERS);
  localparam int CW = $clog2(MAX_CENTERS + 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_CENTERS);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FIN} state_t;

  state_t                state;
  radius_t               radius;
  sq_t                   r2;
  logic [CW-1:0]         cs;
  logic [CW-1:0]         cs_next;
  idx_t                  ps;
  idx_t                  idx;
  logic [CW-1:0]         issue;
  logic [PIPE_DEPTH-1:0] vld;
  idx_t                  id_d [ID_DELAY];
  idx_t                  id_q;
  logic                  found;
  idx_t                  cid;
  coord_t                pt_in [MAX_DIMS];
  coord_t                pt [DIMS];
  sq_t                   sq [DIMS];
  logic                  hit;
  logic                  rd_en;
  logic                  wr_en;
  logic                  out_free;
  logic                  can_store;

  assign pt_in[0] = in_ch.coord_0;
  assign pt_in[1] = in_ch.coord_1;
  assign pt_in[2] = in_ch.coord_2;
  assign pt_in[3] = in_ch.coord_3;
  assign pt_in[4] = in_ch.coord_4;
  assign pt_in[5] = in_ch.coord_5;
  assign pt_in[6] = in_ch.coord_6;
  assign pt_in[7] = in_ch.coord_7;

  assign in_ch.ready = (state == ST_IDLE);
  assign out_free    = !out_ch.valid || out_ch.ready;
  assign rd_en       = (state == ST_SCAN) && (issue < cs);
  assign can_store   = !found && (cs < CNT_MAX);
  assign wr_en       = (state == ST_FIN) && out_free && can_store;
  assign cs_next     = can_store ? cs + 1'b1 : cs;

  for (genvar g = 0; g < DIMS; g++) begin : g_lane
    lc_lane #(
      .MAX_CENTERS (MAX_CENTERS)
    ) u_lane (
      .clk     (clk),
      .wr_en   (wr_en),
      .wr_addr (cs[AW-1:0]),
      .wr_data (pt[g]),
      .rd_en   (rd_en),
      .rd_addr (issue[AW-1:0]),
      .coord   (pt[g]),
      .sq      (sq[g])
    );
  end

  lc_ram #(
    .WIDTH (IDX_W),
    .DEPTH (MAX_CENTERS)
  ) u_id_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (cs[AW-1:0]),
    .wdata (idx),
    .re    (rd_en),
    .raddr (issue[AW-1:0]),
    .rdata (id_q)
  );

  lc_merge #(
    .DIMS (DIMS)
  ) u_merge (
    .clk (clk),
    .sq  (sq),
    .r2  (r2),
    .hit (hit)
  );

  always_ff @(posedge clk) begin
    r2       <= sq_t'(radius) * sq_t'(radius);
    id_d[0]  <= id_q;
    for (int i = 1; i < ID_DELAY; i++) begin
      id_d[i] <= id_d[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      radius       <= '0;
      cs           <= '0;
      ps           <= '0;
      issue        <= '0;
      vld          <= '0;
      found        <= 1'b0;
      out_ch.valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        radius <= cfg_wdata;
      end
      if (out_ch.valid && out_ch.ready && (state != ST_FIN)) begin
        out_ch.valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_ch.valid) begin
            for (int d = 0; d < DIMS; d++) begin
              pt[d] <= pt_in[d];
            end
            if (in_ch.start_set) begin
              cs  <= '0;
              ps  <= '0;
              idx <= '0;
            end else begin
              idx <= ps;
            end
            issue <= '0;
            vld   <= '0;
            found <= 1'b0;
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (rd_en) begin
            issue <= issue + 1'b1;
          end
          if (vld[PIPE_DEPTH-1] && hit) begin
            found <= 1'b1;
            cid   <= id_d[ID_DELAY-1];
            vld   <= '0;
            state <= ST_FIN;
          end else if (!rd_en && (vld == '0)) begin
            state <= ST_FIN;
          end else begin
            vld <= {vld[PIPE_DEPTH-2:0], rd_en};
          end
        end
        ST_FIN: begin
          if (out_free) begin
            cs                    <= cs_next;
            ps                    <= (ps != IDX_SAT) ? ps + 1'b1 : ps;
            out_ch.valid          <= 1'b1;
            out_ch.point_index    <= idx;
            out_ch.cluster_id     <= found ? cid : idx;
            out_ch.is_new_center  <= can_store;
            out_ch.table_overflow <= !found && !can_store;
            out_ch.center_count   <= COUNT_OUT_W'(cs_next);
            state                 <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import lc_pkg::*;

  localparam int DIMS          = DIMS_DEF;
  localparam int MAX_CENTERS   = MAX_CENTERS_DEF;
  localparam int QUIET_LIMIT   = 3000;
  localparam int SETTLE_CYCLES = 16;
  localparam int TAIL_CYCLES   = 300;
  localparam int RANDOM_POINTS = 420;

  typedef struct packed {
    logic                    start_set;
    coord_t [MAX_DIMS-1:0]   coord;
  } point_t;

  typedef struct packed {
    idx_t       point_index;
    idx_t       cluster_id;
    logic       is_new_center;
    logic       table_overflow;
    count_out_t center_count;
  } assignment_t;

  logic    clk;
  logic    rst;
  logic    cfg_we;
  radius_t cfg_wdata;

  lc_in_if  in_ch ();
  lc_out_if out_ch ();

  leader_clustering #(
    .DIMS        (DIMS),
    .MAX_CENTERS (MAX_CENTERS)
  ) DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // Shadow copy of the centre table and counters.
  radius_t radius_q;
  coord_t  centre_coord [MAX_CENTERS][DIMS];
  idx_t    centre_id [MAX_CENTERS];
  int      n_centres;
  int      n_points;

  assignment_t pending_assignments[$];

  int  failures;
  int  n_accepted;
  int  n_sets;
  int  n_new;
  int  n_matched;
  int  n_overflow;
  int  n_radius_writes;
  bit  calm_mode;

  function automatic assignment_t cluster_point(point_t p);
    assignment_t r;
    longint      lim;
    longint      sq_sum;
    longint      diff;
    bit          found;
    lim = longint'(radius_q) * longint'(radius_q);
    if (p.start_set) begin
      n_centres = 0;
      n_points = 0;
      n_sets++;
    end
    r.point_index = idx_t'(n_points);
    r.cluster_id = r.point_index;
    r.is_new_center = 1'b0;
    r.table_overflow = 1'b0;
    found = 1'b0;
    for (int c = 0; c < n_centres && !found; c++) begin
      sq_sum = 0;
      for (int d = 0; d < DIMS; d++) begin
        diff = longint'($signed(p.coord[d])) - longint'($signed(centre_coord[c][d]));
        sq_sum += diff * diff;
      end
      if (sq_sum <= lim) begin
        found = 1'b1;
        r.cluster_id = centre_id[c];
      end
    end
    if (found) begin
      n_matched++;
    end else if (n_centres < MAX_CENTERS) begin
      for (int d = 0; d < DIMS; d++) begin
        centre_coord[n_centres][d] = p.coord[d];
      end
      centre_id[n_centres] = r.point_index;
      n_centres++;
      r.is_new_center = 1'b1;
      n_new++;
    end else begin
      r.table_overflow = 1'b1;
      n_overflow++;
    end
    if (n_points < 65535) begin
      n_points++;
    end
    r.center_count = count_out_t'(n_centres);
    n_accepted++;
    return r;
  endfunction

  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm_mode || r < 50) begin
      return 0;
    end
    if (r < 88) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic coord_t clamp_coord(int v);
    if (v > 32767) begin
      return coord_t'(32767);
    end
    if (v < -32768) begin
      return coord_t'(-32768);
    end
    return coord_t'(v);
  endfunction

  function automatic point_t make_point(logic start, int c0, int c1, int c2, int c3);
    point_t p;
    p.start_set = start;
    p.coord[0] = coord_t'(c0);
    p.coord[1] = coord_t'(c1);
    p.coord[2] = coord_t'(c2);
    p.coord[3] = coord_t'(c3);
    for (int d = 4; d < MAX_DIMS; d++) begin
      p.coord[d] = coord_t'($urandom);
    end
    return p;
  endfunction

  function automatic point_t near_point(point_t seed, int spread);
    point_t p;
    p = seed;
    p.start_set = 1'b0;
    for (int d = 0; d < MAX_DIMS; d++) begin
      if (d < DIMS) begin
        p.coord[d] = clamp_coord(int'($signed(seed.coord[d]))
                                 + int'($urandom_range(0, 2 * spread)) - spread);
      end else begin
        p.coord[d] = coord_t'($urandom);
      end
    end
    return p;
  endfunction

  function automatic void compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endfunction

  task automatic send_point(point_t p);
    int          gap;
    assignment_t predicted;
    gap = idle_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.start_set <= p.start_set;
    in_ch.coord_0   <= p.coord[0];
    in_ch.coord_1   <= p.coord[1];
    in_ch.coord_2   <= p.coord[2];
    in_ch.coord_3   <= p.coord[3];
    in_ch.coord_4   <= p.coord[4];
    in_ch.coord_5   <= p.coord[5];
    in_ch.coord_6   <= p.coord[6];
    in_ch.coord_7   <= p.coord[7];
    do @(posedge clk); while (!in_ch.ready);
    predicted = cluster_point(p);
    pending_assignments = {pending_assignments, predicted};
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (pending_assignments.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_radius(radius_t r);
    cfg_we    <= 1'b1;
    cfg_wdata <= r;
    @(posedge clk);
    cfg_we    <= 1'b0;
    radius_q = r;
    n_radius_writes++;
  endtask

  // Radius is zero after reset, so only identical points share a cluster.
  task automatic test_reset_radius();
    send_point(make_point(1'b1, -32768, -32768, -32768, -32768));
    send_point(make_point(1'b0, 32767, 32767, 32767, 32767));
    send_point(make_point(1'b0, -32768, -32768, -32768, -32768));
    send_point(make_point(1'b0, -32767, -32768, -32768, -32768));
    send_point(make_point(1'b0, 0, 0, 0, 0));
    drain_results();
  endtask

  task automatic test_radius_boundary();
    set_radius(radius_t'(5));
    send_point(make_point(1'b1, 0, 0, 0, 0));
    send_point(make_point(1'b0, 3, 4, 0, 0));
    send_point(make_point(1'b0, 3, 4, 1, 0));
    send_point(make_point(1'b0, -3, -4, 0, 0));
    send_point(make_point(1'b0, 0, 0, 0, -5));
    send_point(make_point(1'b0, 0, 0, 6, 0));
    drain_results();
  endtask

  task automatic test_full_scale_radius();
    set_radius(radius_t'(65535));
    send_point(make_point(1'b1, -32768, 0, 0, 0));
    send_point(make_point(1'b0, 32767, 0, 0, 0));
    send_point(make_point(1'b1, -32768, -32768, -32768, -32768));
    send_point(make_point(1'b0, 32767, 32767, 32767, 32767));
    send_point(make_point(1'b0, 32767, 32767, 32767, -32768));
    send_point(make_point(1'b0, 32767, -32768, 0, 1));
    drain_results();
  endtask

  task automatic test_table_overflow();
    set_radius(radius_t'(0));
    for (int i = 0; i < MAX_CENTERS + 4; i++) begin
      send_point(make_point(i == 0, i - 128, 3 * i, -i, 7));
    end
    send_point(make_point(1'b0, -28, 300, -100, 7));
    send_point(make_point(1'b1, 5, 5, 5, 5));
    drain_results();
  endtask

  task automatic test_random_sets();
    point_t  seeds [4];
    point_t  p;
    radius_t r;
    int      spread;
    int      set_len;
    int      kind;
    int      sent;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: r = radius_t'(1);
        1: r = radius_t'($urandom_range(2, 200));
        2: r = radius_t'(1000);
        3: r = radius_t'(20000);
        4: r = radius_t'(65535);
        default: r = radius_t'(0);
      endcase
      drain_results();
      set_radius(r);
      calm_mode = (phase == 2);
      spread = int'(r) + int'(r) / 4 + 2;
      sent = 0;
      while (sent < RANDOM_POINTS / 6) begin
        for (int s = 0; s < 4; s++) begin
          seeds[s] = make_point(1'b0, $urandom, $urandom, $urandom, $urandom);
        end
        if ($urandom_range(0, 99) < 85) begin
          set_len = $urandom_range(1, 40);
        end else begin
          set_len = $urandom_range(100, 280);
        end
        if (set_len > RANDOM_POINTS / 6 - sent) begin
          set_len = RANDOM_POINTS / 6 - sent;
        end
        for (int i = 0; i < set_len; i++) begin
          kind = $urandom_range(0, 99);
          if (kind < 15) begin
            p = near_point(seeds[$urandom_range(0, 3)], 0);
          end else if (kind < 70) begin
            p = near_point(seeds[$urandom_range(0, 3)], spread);
          end else begin
            p = make_point(1'b0, $urandom, $urandom, $urandom, $urandom);
          end
          p.start_set = (i == 0);
          send_point(p);
          sent++;
        end
      end
    end
    calm_mode = 1'b0;
    drain_results();
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    int hold;
    int gap;
    out_ch.ready <= 1'b0;
    wait (rst === 1'b0);
    @(posedge clk);
    forever begin
      hold = $urandom_range(1, 8);
      out_ch.ready <= 1'b1;
      repeat (hold) @(posedge clk);
      gap = idle_gap();
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : check_results
    assignment_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_assignments.size() == 0) begin
        $error("unexpected word: point_index %0d, cluster_id %0d",
               out_ch.point_index, out_ch.cluster_id);
        failures++;
      end else begin
        want = pending_assignments.pop_front();
        compare_field("point_index", want.point_index, out_ch.point_index);
        compare_field("cluster_id", want.cluster_id, out_ch.cluster_id);
        compare_field("is_new_center", want.is_new_center, out_ch.is_new_center);
        compare_field("table_overflow", want.table_overflow, out_ch.table_overflow);
        compare_field("center_count", want.center_count, out_ch.center_count);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    rst             <= 1'b1;
    cfg_we          <= 1'b0;
    cfg_wdata       <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.start_set <= 1'b0;
    in_ch.coord_0   <= '0;
    in_ch.coord_1   <= '0;
    in_ch.coord_2   <= '0;
    in_ch.coord_3   <= '0;
    in_ch.coord_4   <= '0;
    in_ch.coord_5   <= '0;
    in_ch.coord_6   <= '0;
    in_ch.coord_7   <= '0;
    radius_q = '0;
    n_centres = 0;
    n_points = 0;
    failures = 0;
    calm_mode = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_reset_radius();
    test_radius_boundary();
    test_full_scale_radius();
    test_table_overflow();
    test_random_sets();

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Run covered %0d points in %0d sets under %0d radius settings.",
             n_accepted, n_sets, n_radius_writes);
    $display("%0d new centres, %0d matches, %0d table overflows, %0d mismatches.",
             n_new, n_matched, n_overflow, failures);
    if (failures == 0 && pending_assignments.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
